>>> design/hashed_key_set_table_defines.svh
// assertion macros for the hashed key set table
`ifndef HASHED_KEY_SET_TABLE_DEFINES_SVH
`define HASHED_KEY_SET_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
// checked while out of reset
`define HKST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define HKST_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HKST_ASSERT(lbl, prop, msg)
`define HKST_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> design/hkst_pkg.sv
package hkst_pkg;

    localparam int BUCKETS  = 10;
    localparam int SLOTS    = 8;

    localparam int KEY_W    = 31;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int BUCKET_W = 10;
    localparam int BKT_W    = $clog2(BUCKETS);
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [KEY_W-1:0] key;
    } cmd_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BUCKET_W-1:0] bucket;
    } rsp_item_t;

    typedef logic [SLOTS-1:0][KEY_W-1:0] key_row_t;
    typedef logic [SLOTS-1:0]            valid_row_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic              has_free;
        logic [SLOT_W-1:0] free_slot;
    } match_t;

endpackage

>>> design/hashed_key_set_table.sv
// channel | direction | handshake           | payload
// cmd     | in        | cmd_valid/cmd_stall | cmd_item: command, key
// rsp     | out       | rsp_valid/rsp_stall | rsp_item: status, bucket
//
// one command in flight; a new command is taken only once the last one has left the update state
// steps: the reciprocal-multiply bucket hash, then the bucket row read, then the update
// the hash, row read and update of one command set the rate; rows are one bucket of keys in a registered-read RAM
// reset clears all slot valid flags at once, no clearing pass; key storage is not reset
// a stalled response holds the update cycle; commands are taken while a response waits
`include "hashed_key_set_table_defines.svh"

module hashed_key_set_table (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  hkst_pkg::cmd_item_t cmd_item,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output hkst_pkg::rsp_item_t rsp_item
);

    import hkst_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_UPDATE
    } state_t;

    state_t     state_reg;
    logic       rsp_valid_reg;
    rsp_item_t  rsp_item_reg;
    valid_row_t valid_reg [BUCKETS];

    logic [CMD_W-1:0] cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [BKT_W-1:0] bucket_reg;

    logic             cmd_accept;
    logic             upd_go;
    logic             hash_valid;
    logic [BKT_W-1:0] hash_bucket;
    logic             ram_re;
    logic             ram_we;
    key_row_t         ram_rdata;
    key_row_t         ram_wdata;
    valid_row_t       valid_row;
    match_t           m;
    logic [STATUS_W-1:0] status_next;

    assign cmd_stall  = (state_reg != S_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign upd_go     = (state_reg == S_UPDATE) && (!rsp_valid_reg || !rsp_stall);
    assign ram_re     = (state_reg == S_HASH) && hash_valid;
    assign valid_row  = valid_reg[bucket_reg];

    hkst_hash u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_accept),
        .key       (cmd_item.key),
        .out_valid (hash_valid),
        .bucket    (hash_bucket)
    );

    hkst_ram #(
        .WIDTH ($bits(key_row_t)),
        .DEPTH (BUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (bucket_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (hash_bucket),
        .rdata (ram_rdata)
    );

    hkst_match u_match (
        .keys  (ram_rdata),
        .valid (valid_row),
        .key   (key_reg),
        .m     (m)
    );

    always_comb
    begin
        ram_wdata              = ram_rdata;
        ram_wdata[m.free_slot] = key_reg;
    end

    assign ram_we = upd_go && (cmd_reg == CMD_INSERT) && m.has_free;

    always_comb
    begin
        status_next = ST_ABSENT;
        unique case (cmd_reg) inside
            CMD_INSERT: status_next = m.has_free ? ST_OK : ST_FULL;
            CMD_REMOVE, CMD_SEARCH: status_next = m.hit ? ST_OK : ST_ABSENT;
            default: status_next = ST_ABSENT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            rsp_item_reg  <= '0;
            for (int b = 0; b < BUCKETS; b++)
            begin
                valid_reg[b] <= '0;
            end
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && !upd_go)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_accept)
                    begin
                        state_reg <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    if (hash_valid)
                    begin
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    if (upd_go)
                    begin
                        state_reg           <= S_IDLE;
                        rsp_valid_reg       <= 1'b1;
                        rsp_item_reg.status <= status_next;
                        rsp_item_reg.bucket <= BUCKET_W'(bucket_reg);
                        if (ram_we)
                        begin
                            valid_reg[bucket_reg][m.free_slot] <= 1'b1;
                        end
                        else if ((cmd_reg == CMD_REMOVE) && m.hit)
                        begin
                            valid_reg[bucket_reg][m.hit_slot] <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            cmd_reg <= cmd_item.command;
            key_reg <= cmd_item.key;
        end
        if (ram_re)
        begin
            bucket_reg <= hash_bucket;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    `HKST_ASSERT(a_write_free_slot, ram_we |-> !valid_row[m.free_slot], "insert overwrote a live slot")
    `HKST_ASSERT(a_insert_marks, ram_we |=> valid_reg[bucket_reg][$past(m.free_slot)], "insert not marked valid")
    `HKST_ASSERT(a_update_responds, upd_go |=> rsp_valid_reg && (state_reg == S_IDLE), "update gave no response")
    `HKST_ASSERT(a_bucket_range, rsp_valid_reg |-> (rsp_item_reg.bucket < BUCKETS), "bucket out of range")
    `HKST_ASSERT_RST(a_reset_quiet, !rst_n |-> !rsp_valid_reg && (state_reg == S_IDLE), "busy in reset")

endmodule

>>> design/hkst_ram.sv
module hkst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/hkst_hash.sv
module hkst_hash (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [hkst_pkg::KEY_W-1:0] key,
    output logic                      out_valid,
    output logic [hkst_pkg::BKT_W-1:0] bucket
);

    import hkst_pkg::*;

    // key % BUCKETS from key / BUCKETS by reciprocal multiply, exact for every KEY_W-bit key
    localparam int          SHIFT      = KEY_W + BKT_W;
    localparam int          MAGIC_W    = KEY_W + 1;
    localparam int          PROD_W     = KEY_W + MAGIC_W;
    localparam logic [63:0] MAGIC_WIDE = ((64'd1 << SHIFT) / BUCKETS) + 64'd1;
    localparam logic [MAGIC_W-1:0] MAGIC = MAGIC_WIDE[MAGIC_W-1:0];

    logic              v1_reg;
    logic              v2_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [BKT_W-1:0]  bucket_reg;

    logic [PROD_W-1:0] prod_shr;
    logic [BKT_W-1:0]  quot_lo;
    logic [BKT_W-1:0]  rem_next;

    assign prod_shr = prod_reg >> SHIFT;
    assign quot_lo  = prod_shr[BKT_W-1:0];
    // remainder is below BUCKETS, so the low bits carry it exactly
    assign rem_next = key_reg[BKT_W-1:0] - BKT_W'(quot_lo * BUCKETS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            prod_reg <= key * MAGIC;
            key_reg  <= key;
        end
        if (v1_reg)
        begin
            bucket_reg <= rem_next;
        end
    end

    assign out_valid = v2_reg;
    assign bucket    = bucket_reg;

endmodule

>>> design/hkst_match.sv
module hkst_match (
    input  hkst_pkg::key_row_t         keys,
    input  hkst_pkg::valid_row_t       valid,
    input  logic [hkst_pkg::KEY_W-1:0] key,
    output hkst_pkg::match_t           m
);

    import hkst_pkg::*;

    // walk from the top so the lowest slot wins
    always_comb
    begin
        m = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (valid[s] && (keys[s] == key))
            begin
                m.hit      = 1'b1;
                m.hit_slot = SLOT_W'(s);
            end
            if (!valid[s])
            begin
                m.has_free  = 1'b1;
                m.free_slot = SLOT_W'(s);
            end
        end
    end

endmodule

>>> sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hkst_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_MAX    = '1;
    localparam rsp_item_t        NO_WANT    = '0;

    localparam int DIR_ROWS        = 24;
    localparam int ITEMS_PER_PHASE = 460;
    localparam int POOL_SIZE       = 24;
    localparam int RESET_CYCLES    = 12;
    localparam int TAIL_CYCLES     = 16;
    localparam int CYCLE_LIMIT     = 400000;

    typedef struct {
        cmd_item_t item;
        bit        typed;
        rsp_item_t want;
    } stim_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b1;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_item_t cmd_item  = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp_item;

    // shadow copy of the bucket rows
    logic [KEY_W-1:0] shadow_keys [BUCKETS*SLOTS];
    bit               shadow_used [BUCKETS*SLOTS];

    rsp_item_t        expected_rsp [$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    stim_row_t        stim_rows [DIR_ROWS];

    int error_count    = 0;
    int rsp_count      = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    hashed_key_set_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // applies one command to the shadow rows and returns the response it must produce
    function automatic rsp_item_t apply_to_shadow(input cmd_item_t it);
        rsp_item_t r;
        int        base;
        int        hit_idx;
        int        free_idx;
        base     = int'(it.key % BUCKETS) * SLOTS;
        hit_idx  = -1;
        free_idx = -1;
        // walk downward so the lowest matching and lowest free slots win
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (!shadow_used[base + s])
                free_idx = base + s;
            else if (shadow_keys[base + s] == it.key)
                hit_idx = base + s;
        end
        r.bucket = BUCKET_W'(it.key % BUCKETS);
        r.status = ST_ABSENT;
        case (it.command)
            CMD_INSERT:
            begin
                if (free_idx < 0)
                    r.status = ST_FULL;
                else
                begin
                    shadow_keys[free_idx] = it.key;
                    shadow_used[free_idx] = 1'b1;
                    r.status = ST_OK;
                end
            end
            CMD_REMOVE:
            begin
                if (hit_idx >= 0)
                begin
                    shadow_used[hit_idx] = 1'b0;
                    r.status = ST_OK;
                end
            end
            CMD_SEARCH:
            begin
                if (hit_idx >= 0)
                    r.status = ST_OK;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic send_cmd(input cmd_item_t it, input bit typed, input rsp_item_t want);
        rsp_item_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= it;
        do
            @(posedge clk);
        while (cmd_stall);
        predicted = apply_to_shadow(it);
        expected_rsp.push_back(typed ? want : predicted);
    endtask

    // hold off the sender until every outstanding response is back
    task automatic drain_responses();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_rsp.size() != 0);
    endtask

    always @(posedge clk)
    begin
        rsp_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
                report_mismatch($sformatf("unexpected response status %0d bucket %0d",
                                          rsp_item.status, rsp_item.bucket));
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp_item.status !== want.status)
                    report_mismatch($sformatf("response %0d status %0d, expected %0d",
                                              rsp_count, rsp_item.status, want.status));
                if (rsp_item.bucket !== want.bucket)
                    report_mismatch($sformatf("response %0d bucket %0d, expected %0d",
                                              rsp_count, rsp_item.bucket, want.bucket));
            end
            rsp_count++;
        end
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("ERROR: timeout with %0d responses outstanding", expected_rsp.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        cmd_item_t it;
        int        pick;
        // falling edge at time zero so the reset takes hold before the first clock
        rst_n <= 1'b0;
        stim_rows = '{
            '{'{CMD_SEARCH, 31'd0},          1'b1, '{ST_ABSENT, 10'd0}},
            '{'{CMD_REMOVE, 31'd0},          1'b1, '{ST_ABSENT, 10'd0}},
            '{'{CMD_INSERT, KEY_MAX},        1'b1, '{ST_OK, 10'd7}},
            '{'{CMD_SEARCH, KEY_MAX},        1'b1, '{ST_OK, 10'd7}},
            // duplicate keys in one bucket, removed one copy at a time
            '{'{CMD_INSERT, 31'd0},          1'b0, NO_WANT},
            '{'{CMD_INSERT, 31'd0},          1'b0, NO_WANT},
            '{'{CMD_REMOVE, 31'd0},          1'b0, NO_WANT},
            '{'{CMD_SEARCH, 31'd0},          1'b0, NO_WANT},
            '{'{CMD_REMOVE, 31'd0},          1'b0, NO_WANT},
            '{'{CMD_REMOVE, 31'd0},          1'b0, NO_WANT},
            '{'{CMD_UNUSED, 31'h2AAAAAAA},   1'b0, NO_WANT},
            // fill bucket three
            '{'{CMD_INSERT, 31'd3},          1'b0, NO_WANT},
            '{'{CMD_INSERT, 31'd13},         1'b0, NO_WANT},
            '{'{CMD_INSERT, 31'd23},         1'b0, NO_WANT},
            '{'{CMD_INSERT, 31'd33},         1'b0, NO_WANT},
            '{'{CMD_INSERT, 31'd43},         1'b0, NO_WANT},
            '{'{CMD_INSERT, 31'd53},         1'b0, NO_WANT},
            '{'{CMD_INSERT, 31'd63},         1'b0, NO_WANT},
            '{'{CMD_INSERT, 31'd73},         1'b0, NO_WANT},
            '{'{CMD_INSERT, 31'd2147483643}, 1'b1, '{ST_FULL, 10'd3}},
            '{'{CMD_REMOVE, 31'd43},         1'b0, NO_WANT},
            '{'{CMD_INSERT, 31'd2147483643}, 1'b0, NO_WANT},
            '{'{CMD_SEARCH, 31'd83},         1'b0, NO_WANT},
            // unused command on a stored key still misses
            '{'{CMD_UNUSED, KEY_MAX},        1'b1, '{ST_ABSENT, 10'd7}}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
            send_cmd(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);

        for (int phase = 0; phase < 4; phase++)
        begin
            drain_responses();
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 78;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 78;
                end
                default:
                begin
                    send_idle_pct  = 26;
                    recv_stall_pct = 26;
                end
            endcase
            // pool keys crowd into five buckets so rows fill and hits are common
            foreach (key_pool[i])
                key_pool[i] = KEY_W'($urandom_range(0, 214748363) * 10 + i % 5);
            repeat (ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                    it.command = CMD_INSERT;
                else if (pick < 65)
                    it.command = CMD_REMOVE;
                else if (pick < 95)
                    it.command = CMD_SEARCH;
                else
                    it.command = CMD_UNUSED;
                case ($urandom_range(9))
                    0, 1:    it.key = KEY_W'($urandom);
                    2:       it.key = $urandom_range(1) ? KEY_MAX : '0;
                    default: it.key = key_pool[$urandom_range(POOL_SIZE - 1)];
                endcase
                send_cmd(it, 1'b0, NO_WANT);
            end
        end

        drain_responses();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
